// ===== sv/assert_macros.svh =====
// Assertion macros shared by the keyboard decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PS2A_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define PS2A_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `PS2A_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

// ===== sv/ps2a_pkg.sv =====
// Package: constants, codes, control types and key maps of the keyboard decoder.
`timescale 1ns / 1ps
package ps2a_pkg;

   localparam int RING_DEPTH_DEF = 256;

   localparam logic [7:0] PREFIX_EXT = 8'hE0;
   localparam logic [7:0] SC_LSHIFT  = 8'h2A;
   localparam logic [7:0] SC_RSHIFT  = 8'h36;
   localparam logic [7:0] SC_LSHIFT_REL = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_REL = 8'hB6;
   localparam logic [7:0] SC_CAPS    = 8'h3A;
   localparam logic [7:0] TABLE_LEN  = 8'd58;

   typedef enum logic [1:0] {
      FUNC_SCAN     = 2'd0,
      FUNC_POP_CHAR = 2'd1,
      FUNC_POP_RAW  = 2'd2,
      FUNC_FLUSH    = 2'd3
   } func_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } ring_ctl_type;

   typedef struct packed {
      logic not_empty;
      logic waiting_next;
   } ring_stat_type;

   function automatic logic [6:0] plain_map(input logic [5:0] idx);
      logic [6:0] c;
      unique case (idx)
         6'd2:  c = 7'h31;  6'd3:  c = 7'h32;  6'd4:  c = 7'h33;  6'd5:  c = 7'h34;
         6'd6:  c = 7'h35;  6'd7:  c = 7'h36;  6'd8:  c = 7'h37;  6'd9:  c = 7'h38;
         6'd10: c = 7'h39;  6'd11: c = 7'h30;  6'd12: c = 7'h2D;  6'd13: c = 7'h3D;
         6'd14: c = 7'h08;  6'd15: c = 7'h09;  6'd16: c = 7'h71;  6'd17: c = 7'h77;
         6'd18: c = 7'h65;  6'd19: c = 7'h72;  6'd20: c = 7'h74;  6'd21: c = 7'h79;
         6'd22: c = 7'h75;  6'd23: c = 7'h69;  6'd24: c = 7'h6F;  6'd25: c = 7'h70;
         6'd26: c = 7'h5B;  6'd27: c = 7'h5D;  6'd28: c = 7'h0A;  6'd30: c = 7'h61;
         6'd31: c = 7'h73;  6'd32: c = 7'h64;  6'd33: c = 7'h66;  6'd34: c = 7'h67;
         6'd35: c = 7'h68;  6'd36: c = 7'h6A;  6'd37: c = 7'h6B;  6'd38: c = 7'h6C;
         6'd39: c = 7'h3B;  6'd40: c = 7'h27;  6'd41: c = 7'h60;  6'd43: c = 7'h5C;
         6'd44: c = 7'h7A;  6'd45: c = 7'h78;  6'd46: c = 7'h63;  6'd47: c = 7'h76;
         6'd48: c = 7'h62;  6'd49: c = 7'h6E;  6'd50: c = 7'h6D;  6'd51: c = 7'h2C;
         6'd52: c = 7'h2E;  6'd53: c = 7'h2F;  6'd55: c = 7'h2A;  6'd57: c = 7'h20;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

   function automatic logic [6:0] shifted_map(input logic [5:0] idx);
      logic [6:0] c;
      unique case (idx)
         6'd2:  c = 7'h21;  6'd3:  c = 7'h40;  6'd4:  c = 7'h23;  6'd5:  c = 7'h24;
         6'd6:  c = 7'h25;  6'd7:  c = 7'h5E;  6'd8:  c = 7'h26;  6'd9:  c = 7'h2A;
         6'd10: c = 7'h28;  6'd11: c = 7'h29;  6'd12: c = 7'h5F;  6'd13: c = 7'h2B;
         6'd14: c = 7'h08;  6'd15: c = 7'h09;  6'd16: c = 7'h51;  6'd17: c = 7'h57;
         6'd18: c = 7'h45;  6'd19: c = 7'h52;  6'd20: c = 7'h54;  6'd21: c = 7'h59;
         6'd22: c = 7'h55;  6'd23: c = 7'h49;  6'd24: c = 7'h4F;  6'd25: c = 7'h50;
         6'd26: c = 7'h7B;  6'd27: c = 7'h7D;  6'd28: c = 7'h0A;  6'd30: c = 7'h41;
         6'd31: c = 7'h53;  6'd32: c = 7'h44;  6'd33: c = 7'h46;  6'd34: c = 7'h47;
         6'd35: c = 7'h48;  6'd36: c = 7'h4A;  6'd37: c = 7'h4B;  6'd38: c = 7'h4C;
         6'd39: c = 7'h3A;  6'd40: c = 7'h22;  6'd41: c = 7'h7E;  6'd43: c = 7'h7C;
         6'd44: c = 7'h5A;  6'd45: c = 7'h58;  6'd46: c = 7'h43;  6'd47: c = 7'h56;
         6'd48: c = 7'h42;  6'd49: c = 7'h4E;  6'd50: c = 7'h4D;  6'd51: c = 7'h3C;
         6'd52: c = 7'h3E;  6'd53: c = 7'h3F;  6'd55: c = 7'h2A;  6'd57: c = 7'h20;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== sv/ps2_set1_scancode_to_ascii_fifo.sv =====
// Top level: PS/2 set-1 keyboard decoder with character and raw scan-code rings.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
//   Requests arrive on req_ (func, scan_byte); every request yields exactly one
//   response on rsp_. func 0 pushes a scan code into the raw ring, translates it
//   and pushes any non-zero character into the character ring; func 1 pops a
//   character, func 2 pops a raw code, func 3 flushes the character ring.
//   A request is taken into an input register, then one pass of table lookup,
//   flag update and ring push/pop fills the response register, which drives
//   rsp_tvalid. One request per cycle is sustained while rsp_tready stays high;
//   each ring memory has one write and one registered read port per cycle.
//   Popped data comes from the ring read register, loaded in the same pass.
//   Reset clears the shift and caps flags and all ring pointers; ring memories
//   are not cleared and need no clearing pass. While rsp_tready is low the
//   response holds, the input register fills and then req_tready drops.
module ps2_set1_scancode_to_ascii_fifo
   import ps2a_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [1:0] func, [9:2] scan_byte, [15:10] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] char_valid, [7:1] char_out, [8] raw_valid, [16:9] raw_out,
   // [17] chars_waiting, [18] raws_waiting, [23:19] zero
   output logic [23:0] rsp_tdata
);

   logic       in_valid_ff;
   func_type   func_ff;
   logic [7:0] scan_ff;
   logic       advance;

   ring_ctl_type  char_ctl, raw_ctl;
   ring_stat_type char_stat, raw_stat;
   logic [6:0]    char_rd_ff;
   logic [7:0]    raw_rd_ff;
   logic [6:0]    xlat_char;

   logic       rsp_valid_ff;
   logic       char_valid_ff, char_valid_in;
   logic       char_pop_ff;
   logic [6:0] xlat_ff;
   logic       raw_valid_ff, raw_valid_in;
   logic       chars_wait_ff, raws_wait_ff;
   logic [6:0] char_field;
   logic [7:0] raw_field;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // hold the request payload until it is processed
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         func_ff <= func_type'(req_tdata[1:0]);
         scan_ff <= req_tdata[9:2];
      end
   end

   ps2a_xlate u_xlate (
      .clock    (clock),
      .reset    (reset),
      .en       (advance && func_ff == FUNC_SCAN),
      .scan     (scan_ff),
      .char_out (xlat_char)
   );

   assign char_ctl.push  = advance && func_ff == FUNC_SCAN && xlat_char != 7'h00;
   assign char_ctl.pop   = advance && func_ff == FUNC_POP_CHAR;
   assign char_ctl.flush = advance && func_ff == FUNC_FLUSH;
   assign raw_ctl.push   = advance && func_ff == FUNC_SCAN;
   assign raw_ctl.pop    = advance && func_ff == FUNC_POP_RAW;
   assign raw_ctl.flush  = 1'b0;

   ps2a_ring #(.DEPTH(RING_DEPTH), .DATA_W(7)) u_char_ring (
      .clock      (clock),
      .reset      (reset),
      .ctl        (char_ctl),
      .push_data  (xlat_char),
      .stat       (char_stat),
      .rd_data_ff (char_rd_ff)
   );

   ps2a_ring #(.DEPTH(RING_DEPTH), .DATA_W(8)) u_raw_ring (
      .clock      (clock),
      .reset      (reset),
      .ctl        (raw_ctl),
      .push_data  (scan_ff),
      .stat       (raw_stat),
      .rd_data_ff (raw_rd_ff)
   );

   assign char_valid_in = char_ctl.push || (char_ctl.pop && char_stat.not_empty);
   assign raw_valid_in  = raw_ctl.pop && raw_stat.not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         char_valid_ff <= char_valid_in;
         char_pop_ff   <= (func_ff == FUNC_POP_CHAR);
         xlat_ff       <= xlat_char;
         raw_valid_ff  <= raw_valid_in;
         chars_wait_ff <= char_stat.waiting_next;
         raws_wait_ff  <= raw_stat.waiting_next;
      end
   end

   assign char_field = !char_valid_ff ? 7'h00 : (char_pop_ff ? char_rd_ff : xlat_ff);
   assign raw_field  = raw_valid_ff ? raw_rd_ff : 8'h00;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, raws_wait_ff, chars_wait_ff, raw_field, raw_valid_ff,
                        char_field, char_valid_ff};

   `PS2A_ASSERT(a_char_nonzero, clock, reset, (rsp_valid_ff && char_valid_ff && !char_pop_ff) |-> (xlat_ff != 7'h00), "translated character is zero")
   `PS2A_ASSERT_NEVER(a_one_kind, clock, reset, rsp_valid_ff && char_valid_ff && raw_valid_ff, "response carries both a character and a raw code")

endmodule

// ===== sv/ps2a_xlate.sv =====
// Scan-code translator: shift and caps-lock flags and the key map lookup.
`timescale 1ns / 1ps
module ps2a_xlate
   import ps2a_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic [7:0] scan,
   output logic [6:0] char_out
);

   logic shift_ff, shift_in;
   logic caps_ff, caps_in;
   logic [6:0] map_char;

   always_comb begin
      shift_in = shift_ff;
      caps_in  = caps_ff;
      char_out = 7'h00;
      map_char = shift_ff ? shifted_map(scan[5:0]) : plain_map(scan[5:0]);
      priority if (scan == PREFIX_EXT) begin
         char_out = 7'h00;
      end else if (scan == SC_LSHIFT || scan == SC_RSHIFT) begin
         shift_in = 1'b1;
      end else if (scan == SC_LSHIFT_REL || scan == SC_RSHIFT_REL) begin
         shift_in = 1'b0;
      end else if (scan == SC_CAPS) begin
         caps_in = !caps_ff;
      end else if (scan[7] || scan >= TABLE_LEN) begin
         char_out = 7'h00;
      end else begin
         char_out = map_char;
         // caps lock swaps the case of letters only
         if (caps_ff && ((map_char >= 7'h61 && map_char <= 7'h7A) ||
                         (map_char >= 7'h41 && map_char <= 7'h5A))) begin
            char_out = map_char ^ 7'h20;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         caps_ff  <= 1'b0;
      end else if (en) begin
         shift_ff <= shift_in;
         caps_ff  <= caps_in;
      end
   end

endmodule

// ===== sv/ps2a_ring.sv =====
// Ring buffer with one slot kept empty; a push into a full ring drops the oldest entry.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ps2a_ring
   import ps2a_pkg::*;
#(
   parameter int DEPTH  = RING_DEPTH_DEF,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  ring_ctl_type      ctl,
   input  logic [DATA_W-1:0] push_data,
   output ring_stat_type     stat,
   output logic [DATA_W-1:0] rd_data_ff
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  wr_next, rd_next;

   assign wr_next = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;

   assign stat.not_empty = (rd_ptr_ff != wr_ptr_ff);

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      priority if (ctl.flush) begin
         rd_ptr_in = '0;
         wr_ptr_in = '0;
      end else if (ctl.push) begin
         wr_ptr_in = wr_next;
         // full: drop the oldest entry
         if (wr_next == rd_ptr_ff) begin
            rd_ptr_in = rd_next;
         end
      end else if (ctl.pop && stat.not_empty) begin
         rd_ptr_in = rd_next;
      end
   end

   assign stat.waiting_next = (rd_ptr_in != wr_ptr_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (ctl.pop && stat.not_empty) begin
         rd_data_ff <= mem_ff[rd_ptr_ff];
      end
   end

   `PS2A_ASSERT(a_flush_empties, clock, reset, ctl.flush |=> (rd_ptr_ff == '0 && wr_ptr_ff == '0), "ring not empty after flush")
   `PS2A_ASSERT_NEVER(a_ptr_range, clock, reset, wr_ptr_ff > LAST_PTR || rd_ptr_ff > LAST_PTR, "ring pointer beyond depth")

endmodule

// ===== verif/tb_ps2_set1_scancode_to_ascii_fifo.sv =====
// Testbench for the PS/2 set-1 decoder: empty-ring requests, directed keys, ring wrap and random typing, self-checked.
`timescale 1ns / 1ps
module tb_ps2_set1_scancode_to_ascii_fifo
   import ps2a_pkg::*;
();

   localparam int          RING_CAP    = RING_DEPTH_DEF - 1;
   localparam int          IDLE_LIMIT  = 1000;
   localparam int          DRAIN_WAIT  = 8;
   localparam logic [7:0]  KEY_RELEASE = 8'h80;

   // Key maps indexed by scan code, entry 0 first.
   localparam bit [0:57][7:0] PLAIN_KEYS = {
      8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
      8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
      8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20};
   localparam bit [0:57][7:0] SHIFTED_KEYS = {
      8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
      8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
      8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
      8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20};

   typedef struct {
      bit       char_valid;
      bit [6:0] char_out;
      bit       raw_valid;
      bit [7:0] raw_out;
      bit       chars_waiting;
      bit       raws_waiting;
   } key_response_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;

   // Predictor state
   bit               shift_down;
   bit               caps_active;
   bit [6:0]         char_store[$];
   bit [7:0]         raw_store[$];
   key_response_type pending_responses[$];

   int  errors;
   int  idle_cycles;
   int  stall_left;
   bit  req_gaps_on;
   bit  rsp_stalls_on;
   int  n_requests;
   int  n_chars;
   int  n_pops;
   int  n_flushes;
   int  n_dropped;

   ps2_set1_scancode_to_ascii_fifo DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic bit [6:0] translate_code(input logic [7:0] code);
      bit [6:0] c;
      if (code == PREFIX_EXT) return 7'd0;
      if (code == SC_LSHIFT || code == SC_RSHIFT) begin
         shift_down = 1'b1;
         return 7'd0;
      end
      if (code == SC_LSHIFT_REL || code == SC_RSHIFT_REL) begin
         shift_down = 1'b0;
         return 7'd0;
      end
      if (code == SC_CAPS) begin
         caps_active = !caps_active;
         return 7'd0;
      end
      if ((code & KEY_RELEASE) != 8'd0 || code >= TABLE_LEN) return 7'd0;
      c = shift_down ? SHIFTED_KEYS[code][6:0] : PLAIN_KEYS[code][6:0];
      // Caps lock swaps the case of letters only
      if (caps_active) begin
         if (c >= 7'h61 && c <= 7'h7A) c = c - 7'h20;
         else if (c >= 7'h41 && c <= 7'h5A) c = c + 7'h20;
      end
      return c;
   endfunction

   task automatic decode_request(input func_type func, input logic [7:0] code);
      key_response_type r;
      bit [6:0]         c;
      r = '{default: 0};
      n_requests++;
      case (func)
         FUNC_SCAN: begin
            // A full ring loses its oldest entry
            if (raw_store.size() == RING_CAP) begin
               void'(raw_store.pop_front());
               n_dropped++;
            end
            raw_store.push_back(code);
            c = translate_code(code);
            if (c != 7'd0) begin
               if (char_store.size() == RING_CAP) begin
                  void'(char_store.pop_front());
                  n_dropped++;
               end
               char_store.push_back(c);
               r.char_valid = 1'b1;
               r.char_out   = c;
               n_chars++;
            end
         end
         FUNC_POP_CHAR: begin
            n_pops++;
            if (char_store.size() != 0) begin
               r.char_valid = 1'b1;
               r.char_out   = char_store.pop_front();
            end
         end
         FUNC_POP_RAW: begin
            n_pops++;
            if (raw_store.size() != 0) begin
               r.raw_valid = 1'b1;
               r.raw_out   = raw_store.pop_front();
            end
         end
         FUNC_FLUSH: begin
            n_flushes++;
            char_store.delete();
         end
      endcase
      r.chars_waiting = (char_store.size() != 0);
      r.raws_waiting  = (raw_store.size() != 0);
      pending_responses.push_back(r);
   endtask

   // Drive one request and hold it until it is taken; valid stays high for a back-to-back follow-up.
   task automatic send_request(input func_type func, input logic [7:0] code);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, code, func};
      do @(posedge clock); while (!req_tready);
      decode_request(func, code);
   endtask

   task automatic send_scan(input logic [7:0] code);
      send_request(FUNC_SCAN, code);
   endtask

   task automatic compare_field(input string field, input int unsigned want, got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : response_check
      key_response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            $display("%0t ns: unexpected response, expected none, actual 0x%h",
                     $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_responses.pop_front();
            compare_field("char_valid", want.char_valid, rsp_tdata[0]);
            compare_field("char_out", want.char_out, rsp_tdata[7:1]);
            compare_field("raw_valid", want.raw_valid, rsp_tdata[8]);
            compare_field("raw_out", want.raw_out, rsp_tdata[16:9]);
            compare_field("chars_waiting", want.chars_waiting, rsp_tdata[17]);
            compare_field("raws_waiting", want.raws_waiting, rsp_tdata[18]);
         end
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_stalls_on) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no request or response moved for %0d cycles", $time, idle_cycles);
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic test_empty_after_reset();
      send_request(FUNC_POP_CHAR, 8'hFF);
      send_request(FUNC_POP_RAW, 8'h00);
      send_request(FUNC_FLUSH, 8'hA5);
   endtask

   task automatic test_directed_keys();
      send_scan(8'h00);          // table start, no character
      send_scan(8'h1E);          // a
      send_scan(SC_LSHIFT);
      send_scan(8'h1E);          // A
      send_scan(8'h02);          // !
      send_scan(SC_CAPS);
      send_scan(8'h1E);          // shift and caps cancel on letters
      send_scan(8'h0C);          // caps leaves symbols alone
      send_scan(SC_LSHIFT_REL);
      send_scan(8'h1E);
      send_scan(8'h39);          // space, last table entry
      send_scan(SC_CAPS);
      send_scan(SC_RSHIFT);
      send_scan(8'h35);
      send_scan(SC_RSHIFT_REL);
      send_scan(PREFIX_EXT);
      send_scan(8'h9E);          // release code
      send_scan(TABLE_LEN);      // first code past the table
      send_scan(8'hFF);
      send_request(FUNC_POP_CHAR, 8'h00);
      send_request(FUNC_POP_RAW, 8'h00);
      send_request(FUNC_FLUSH, 8'h00);
      send_request(FUNC_POP_CHAR, 8'h00);
      // Empty the raw ring, then pop once more from it
      while (raw_store.size() != 0) send_request(FUNC_POP_RAW, 8'h00);
      send_request(FUNC_POP_RAW, 8'h00);
   endtask

   // Overfill both rings, then pop from each and flush the characters.
   task automatic test_ring_wrap();
      req_gaps_on = 1'b0;
      repeat (RING_CAP + 5) send_scan(8'($urandom_range(16, 25)));
      req_gaps_on = 1'b1;
      repeat (8) send_request(FUNC_POP_CHAR, 8'($urandom_range(0, 255)));
      send_request(FUNC_FLUSH, 8'($urandom_range(0, 255)));
      send_request(FUNC_POP_CHAR, 8'($urandom_range(0, 255)));
      repeat (8) send_request(FUNC_POP_RAW, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_random_typing(input int n_items);
      int         sent;
      int         pick;
      logic [7:0] key;
      logic [7:0] shift_key;
      sent = 0;
      while (sent < n_items) begin
         // Toggle idling now and then for stretches without gaps or stalls
         if ($urandom_range(0, 59) == 0) req_gaps_on = !req_gaps_on;
         if ($urandom_range(0, 59) == 0) rsp_stalls_on = !rsp_stalls_on;
         pick = $urandom_range(0, 99);
         key  = 8'($urandom_range(0, 57));
         shift_key = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
         if (pick < 36) begin
            send_scan(key);
            send_scan(key | KEY_RELEASE);
            sent += 2;
         end else if (pick < 46) begin
            send_scan(shift_key);
            send_scan(key);
            send_scan(key | KEY_RELEASE);
            send_scan(shift_key | KEY_RELEASE);
            sent += 4;
         end else if (pick < 50) begin
            send_scan(SC_CAPS);
            send_scan(SC_CAPS | KEY_RELEASE);
            sent += 2;
         end else if (pick < 54) begin
            send_scan(PREFIX_EXT);
            send_scan(8'($urandom_range(0, 255)));
            sent += 2;
         end else if (pick < 60) begin
            send_scan(8'($urandom_range(0, 255)));
            sent++;
         end else if (pick < 78) begin
            send_request(FUNC_POP_CHAR, 8'($urandom_range(0, 255)));
            sent++;
         end else if (pick < 96) begin
            send_request(FUNC_POP_RAW, 8'($urandom_range(0, 255)));
            sent++;
         end else begin
            send_request(FUNC_FLUSH, 8'($urandom_range(0, 255)));
            sent++;
         end
      end
   endtask

   initial begin
      errors        = 0;
      idle_cycles   = 0;
      stall_left    = 0;
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 16'd0;
      rsp_tready <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_after_reset();
      test_directed_keys();
      test_ring_wrap();
      test_random_typing(230);

      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Covered %0d requests: %0d characters decoded, %0d pops, %0d flushes,",
               n_requests, n_chars, n_pops, n_flushes);
      $display("with %0d entries lost to full rings, under random gaps and back-pressure.",
               n_dropped);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== ps2_set1_scancode_to_ascii_fifo.f =====
+incdir+sv
sv/ps2a_pkg.sv
sv/ps2a_xlate.sv
sv/ps2a_ring.sv
sv/ps2_set1_scancode_to_ascii_fifo.sv
verif/tb_ps2_set1_scancode_to_ascii_fifo.sv
